@@ hdl/mvm_pkg.sv @@
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared widths, codes and the queue entry type of the matrix-vector core.
// ----------------------------------------------------------------------------
package mvm_pkg;

  // Field widths fixed by the block's interface.
  localparam int CFG_W  = 11;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 48;
  localparam int ROW_W  = 10;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_SIZE    = 1024;
  localparam int DEF_QUEUE_DEPTH = 4;

  // Reset value of the matrix size register.
  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  // Request type codes.
  localparam logic REQ_VECTOR = 1'b0;
  localparam logic REQ_MATRIX = 1'b1;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    logic                    is_matrix;
    logic signed [VAL_W-1:0] value;
    logic                    end_row;
    logic                    last_row;
    logic [ROW_W-1:0]        row_index;
  } mvm_op_t;

  localparam int OP_W = $bits(mvm_op_t);

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } mvm_q_status_t;

endpackage

@@ hdl/mvm_in_if.sv @@
// ----------------------------------------------------------------------------
// mvm_in_if
// Input item channel: request type and element value with valid and ready.
// ----------------------------------------------------------------------------
interface mvm_in_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic signed [mvm_pkg::VAL_W-1:0] element_value;

  modport source (output valid, output req_type, output element_value, input ready);
  modport sink   (input valid, input req_type, input element_value, output ready);
endinterface

@@ hdl/mvm_out_if.sv @@
// ----------------------------------------------------------------------------
// mvm_out_if
// Result item channel: row dot product, row index and last-row flag.
// ----------------------------------------------------------------------------
interface mvm_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [mvm_pkg::ACC_W-1:0] row_result;
  logic [mvm_pkg::ROW_W-1:0]        row_index;
  logic                             last_row;

  modport source (output valid, output row_result, output row_index, output last_row,
                  input ready);
  modport sink   (input valid, input row_result, input row_index, input last_row,
                  output ready);
endinterface

@@ hdl/mvm_cfg_if.sv @@
// ----------------------------------------------------------------------------
// mvm_cfg_if
// Configuration write channel carrying the matrix size register.
// ----------------------------------------------------------------------------
interface mvm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [mvm_pkg::CFG_W-1:0] matrix_size;

  modport source (output valid, output matrix_size, input ready);
  modport sink   (input valid, input matrix_size, output ready);
endinterface

@@ hdl/mvm_front.sv @@
// ----------------------------------------------------------------------------
// mvm_front
// Accepts items, tracks load position and row/column counters, classifies
// each item and pushes it into the queue with its vector store address.
// ----------------------------------------------------------------------------
module mvm_front #(
  parameter  int MAX_SIZE = mvm_pkg::DEF_MAX_SIZE,
  localparam int IDX_W    = $clog2(MAX_SIZE),
  localparam int CNT_W    = IDX_W + 1,
  localparam int Q_W      = IDX_W + mvm_pkg::OP_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mvm_in_if.sink                req_i,
  input  logic [CNT_W-1:0]      size_i,
  input  mvm_pkg::mvm_q_status_t q_status_i,
  output logic                  push_o,
  output logic [Q_W-1:0]        push_data_o
);

  logic [IDX_W-1:0] load_q, load_d;
  logic [IDX_W-1:0] col_q, col_d;
  logic [IDX_W-1:0] row_q, row_d;
  logic [CNT_W-1:0] load_next, col_next, row_next;
  logic             accept, is_matrix, end_row, last_row;
  logic [IDX_W-1:0] addr;
  mvm_pkg::mvm_op_t op;

  assign req_i.ready = !q_status_i.full;
  assign accept      = req_i.valid && req_i.ready;
  assign is_matrix   = (req_i.req_type == mvm_pkg::REQ_MATRIX);

  assign load_next = CNT_W'(load_q) + CNT_W'(1);
  assign col_next  = CNT_W'(col_q) + CNT_W'(1);
  assign row_next  = CNT_W'(row_q) + CNT_W'(1);
  assign end_row   = (col_next >= size_i);
  assign last_row  = (row_next >= size_i);

  always_comb begin
    load_d = load_q;
    col_d  = col_q;
    row_d  = row_q;
    if (accept) begin
      if (!is_matrix) begin
        load_d = (load_next >= size_i) ? '0 : load_next[IDX_W-1:0];
      end else if (end_row) begin
        col_d = '0;
        row_d = last_row ? '0 : row_next[IDX_W-1:0];
      end else begin
        col_d = col_next[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      load_q <= load_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  always_comb begin
    op.is_matrix = is_matrix;
    op.value     = req_i.element_value;
    op.end_row   = is_matrix && end_row;
    op.last_row  = last_row;
    op.row_index = mvm_pkg::ROW_W'(row_q);
  end

  assign addr        = is_matrix ? col_q : load_q;
  assign push_o      = accept;
  assign push_data_o = {addr, op};

`ifndef SYNTH
  a_row_end_clears_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_matrix && end_row |=> col_q == '0)
    else $error("column counter not cleared at end of row");
`endif

endmodule

@@ hdl/mvm_queue.sv @@
// ----------------------------------------------------------------------------
// mvm_queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mvm_queue #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = mvm_pkg::DEF_QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [WIDTH-1:0]       push_data_i,
  input  logic                   pop_i,
  output logic [WIDTH-1:0]       pop_data_o,
  output mvm_pkg::mvm_q_status_t status_o
);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into a full queue");
  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from an empty queue");
`endif

endmodule

@@ hdl/mvm_back.sv @@
// ----------------------------------------------------------------------------
// mvm_back
// Executes queued items: vector store writes and reads, multiply, row
// accumulation and the registered result stage.
// ----------------------------------------------------------------------------
module mvm_back #(
  parameter  int MAX_SIZE = mvm_pkg::DEF_MAX_SIZE,
  localparam int IDX_W    = $clog2(MAX_SIZE),
  localparam int Q_W      = IDX_W + mvm_pkg::OP_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mvm_pkg::mvm_q_status_t q_status_i,
  input  logic [Q_W-1:0]         q_data_i,
  output logic                   pop_o,
  mvm_out_if.source              res_o
);

  localparam int VAL_W  = mvm_pkg::VAL_W;
  localparam int PROD_W = mvm_pkg::PROD_W;
  localparam int ACC_W  = mvm_pkg::ACC_W;
  localparam int ROW_W  = mvm_pkg::ROW_W;

  logic signed [VAL_W-1:0] vec_mem [MAX_SIZE];

  mvm_pkg::mvm_op_t        op;
  logic [IDX_W-1:0]        addr;
  logic                    adv;

  // Stage 1: vector read.
  logic                    s1_valid_q;
  logic signed [VAL_W-1:0] s1_a_q, rd_q;
  logic                    s1_end_q, s1_last_q;
  logic [ROW_W-1:0]        s1_row_q;

  // Stage 2: product.
  logic                     s2_valid_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     s2_end_q, s2_last_q;
  logic [ROW_W-1:0]         s2_row_q;

  // Accumulator and result register.
  logic signed [ACC_W-1:0] acc_q, acc_d, sum;
  logic                    out_valid_q;
  logic signed [ACC_W-1:0] out_result_q;
  logic [ROW_W-1:0]        out_row_q;
  logic                    out_last_q;

  assign op   = mvm_pkg::mvm_op_t'(q_data_i[mvm_pkg::OP_W-1:0]);
  assign addr = q_data_i[Q_W-1:mvm_pkg::OP_W];

  // The pipeline moves whenever the result register is free or being taken.
  assign adv   = !out_valid_q || res_o.ready;
  assign pop_o = adv && !q_status_i.empty;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (!op.is_matrix) begin
        vec_mem[addr] <= op.value;
      end else begin
        rd_q <= vec_mem[addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= pop_o && op.is_matrix;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_a_q    <= op.value;
      s1_end_q  <= op.end_row;
      s1_last_q <= op.last_row;
      s1_row_q  <= op.row_index;
      prod_q    <= prod_d;
      s2_end_q  <= s1_end_q;
      s2_last_q <= s1_last_q;
      s2_row_q  <= s1_row_q;
    end
  end

  assign prod_d = s1_a_q * rd_q;
  assign sum    = acc_q + ACC_W'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (adv && s2_valid_q) begin
      acc_d = s2_end_q ? '0 : sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (adv) begin
        out_valid_q <= s2_valid_q && s2_end_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q && s2_end_q) begin
      out_result_q <= sum;
      out_row_q    <= s2_row_q;
      out_last_q   <= s2_last_q;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.row_result = out_result_q;
  assign res_o.row_index  = out_row_q;
  assign res_o.last_row   = out_last_q;

`ifndef SYNTH
  a_stall_holds_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(acc_q))
    else $error("accumulator changed while the pipeline was stalled");
  a_row_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s2_valid_q && s2_end_q |=> res_o.valid)
    else $error("row end did not produce a result");
`endif

endmodule

@@ hdl/matrix_vector_multiply_core.sv @@
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core
// Streaming y = A*x for a square matrix of configurable size, Q2.14 inputs
// and exact Q20.28 row sums.
// ----------------------------------------------------------------------------
// Usage: write matrix_size on cfg_i while the block is idle (it is always
// ready). Send the vector on req_i as req_type 0 items, in order; the load
// position wraps after the size in use. Then stream the matrix row-major as
// req_type 1 items. Each matrix item is multiplied by the stored vector
// element of its column and summed; the last column of a row produces one
// item on res_o with the row sum, the row index and a last-row flag.
// A size of 0 acts as 1 and one above MAX_SIZE acts as MAX_SIZE.
// Throughput is one item per cycle on req_i while the queue is not full, set
// by a single multiply and a single 48-bit add per item in the back end. The
// last element of a row then passes from the queue through the vector store
// read, the multiply, then the accumulate into the result register on res_o.
// Reset clears all counters and the accumulator and sets the size to 1024;
// vector store contents are undefined until loaded. When res_o stalls, the
// result register holds, the back-end pipeline freezes and the front end
// keeps accepting until the QUEUE_DEPTH entry queue is full.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_core #(
  parameter int MAX_SIZE    = mvm_pkg::DEF_MAX_SIZE,
  parameter int QUEUE_DEPTH = mvm_pkg::DEF_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mvm_cfg_if.sink    cfg_i,
  mvm_in_if.sink     req_i,
  mvm_out_if.source  res_o
);

  localparam int IDX_W = $clog2(MAX_SIZE);
  localparam int CNT_W = IDX_W + 1;
  localparam int CMP_W = (CNT_W > mvm_pkg::CFG_W) ? CNT_W : mvm_pkg::CFG_W;
  localparam int Q_W   = IDX_W + mvm_pkg::OP_W;

  logic [mvm_pkg::CFG_W-1:0] size_q;
  logic [CMP_W-1:0]          size_raw;
  logic [CNT_W-1:0]          size_use;

  logic                      push;
  logic [Q_W-1:0]            push_data;
  logic                      pop;
  logic [Q_W-1:0]            pop_data;
  mvm_pkg::mvm_q_status_t    q_status;

  // The size register takes any write; no busy condition is needed.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= mvm_pkg::SIZE_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      size_q <= cfg_i.matrix_size;
    end
  end

  // Clamp the written size to the range the storage supports.
  assign size_raw = CMP_W'(size_q);

  always_comb begin
    if (size_raw == '0) begin
      size_use = CNT_W'(1);
    end else if (size_raw > CMP_W'(MAX_SIZE)) begin
      size_use = CNT_W'(MAX_SIZE);
    end else begin
      size_use = size_raw[CNT_W-1:0];
    end
  end

  mvm_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .size_i      (size_use),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mvm_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  mvm_back #(
    .MAX_SIZE (MAX_SIZE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .q_data_i   (pop_data),
    .pop_o      (pop),
    .res_o      (res_o)
  );

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming matrix-vector multiply core. Items
// are driven on the request channel while a predictor in the bench keeps its
// own vector store, counters and row sum. Each result item is compared with
// the oldest predicted row sum. A short table of directed items comes first,
// then random matrix sizes with random vectors and rows, under changing
// stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SIZE = mvm_pkg::DEF_MAX_SIZE;
  localparam int VAL_W    = mvm_pkg::VAL_W;
  localparam int PROD_W   = mvm_pkg::PROD_W;
  localparam int ACC_W    = mvm_pkg::ACC_W;
  localparam int ROW_W    = mvm_pkg::ROW_W;
  localparam int CFG_W    = mvm_pkg::CFG_W;

  // A result leaves once the last element of its row is through the pipeline.
  // This adds margin for it to empty before the size register is touched.
  localparam int SETTLE_CYCLES = 8;

  // Upper bound on the final wait for outstanding row sums.
  localparam int DRAIN_LIMIT = 200000;

  // Whole-run watchdog, in ns. A clean run needs well under a millisecond.
  localparam int RUN_LIMIT_NS = 10_000_000;

  // Random items per stall pattern, not counting the directed table and the
  // over-range size check.
  localparam int ITEMS_PER_PATTERN = 200;

  // One expected result item.
  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic [ROW_W-1:0]        row;
    logic                    last;
  } row_sum_t;

  // One row of the directed table: a size write or an item on the request
  // channel, optionally with the expected result typed in.
  typedef enum logic [1:0] {
    STEP_SIZE,
    STEP_VECTOR,
    STEP_MATRIX
  } step_kind_e;

  typedef struct packed {
    step_kind_e  kind;
    logic [15:0] value;
    logic        typed;
    row_sum_t    want;
  } step_t;

  localparam row_sum_t NO_SUM = '0;

  logic clk;
  logic rst_n;

  mvm_cfg_if cfg_if ();
  mvm_in_if  req_if ();
  mvm_out_if res_if ();

  matrix_vector_multiply_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // --------------------------------------------------------------------------
  // Predictor state. It mirrors the block: the stored vector, the load
  // position, the column and row counters, the running row sum and the size
  // register. It is advanced at the clock edge where an item is accepted.
  // --------------------------------------------------------------------------
  logic signed [VAL_W-1:0] vec_mem [MAX_SIZE];
  int unsigned             load_pos;
  int unsigned             col_cnt;
  int unsigned             row_cnt;
  logic [ACC_W-1:0]        row_acc;
  logic [CFG_W-1:0]        size_reg;

  // Row sums predicted but not yet seen on the result channel, oldest first.
  row_sum_t row_sums_due [$];

  int fail_count;

  // Stall controls read by the two channel processes.
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  step_t dir_steps [$];

  // The size register clamps: zero behaves as one, anything above the maximum
  // behaves as the maximum.
  function automatic int unsigned active_size();
    int unsigned n;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > MAX_SIZE) n = MAX_SIZE;
    return n;
  endfunction

  // Applies one accepted item to the predictor. Returns 1 when the item ends
  // a row, with the row sum, its index and the last-row flag in sum_out.
  function automatic bit predict_row_sum(input logic req_type,
                                         input logic signed [VAL_W-1:0] value,
                                         output row_sum_t sum_out);
    int unsigned n;
    int unsigned pos;
    int unsigned col;
    logic signed [PROD_W-1:0] prod;
    bit last;
    n = active_size();
    sum_out = '0;
    if (req_type == mvm_pkg::REQ_VECTOR) begin
      // A load position left beyond a shrunken size still writes, then wraps.
      pos = load_pos % MAX_SIZE;
      vec_mem[pos] = value;
      load_pos = (pos + 1 >= n) ? 0 : pos + 1;
      return 1'b0;
    end
    col = col_cnt % MAX_SIZE;
    prod = value * vec_mem[col];
    row_acc = row_acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    if (col_cnt + 1 < n) begin
      col_cnt = col_cnt + 1;
      return 1'b0;
    end
    // Row ends here. A row counter at or past n - 1 marks the final row.
    last = (row_cnt + 1 >= n);
    sum_out.sum = row_acc;
    sum_out.row = row_cnt[ROW_W-1:0];
    sum_out.last = last;
    row_acc = '0;
    col_cnt = 0;
    row_cnt = last ? 0 : row_cnt + 1;
    return 1'b1;
  endfunction

  // Random element value, with the corner values drawn more often.
  function automatic logic [VAL_W-1:0] rand_element();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 16'h7FFF;
        1:       return 16'h8000;
        2:       return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return VAL_W'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Clock: 12 ns period.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result receiver. Ready changes only at the falling edge. A hold-off
  // request from the stimulus forces ready low for that many cycles, counted
  // here, so the block fills its queue and stalls its input.
  // --------------------------------------------------------------------------
  initial begin : result_ready
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left = hold_left - 1;
      end else begin
        res_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker. Samples at the rising edge, so it sees the values that
  // the block presented during the cycle, before any update at this edge.
  // --------------------------------------------------------------------------
  initial begin : result_check
    row_sum_t want;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready) begin
        if (row_sums_due.size() == 0) begin
          $display("%0t: unexpected result item: sum %0d row %0d last %0b", $time,
                   res_if.row_result, res_if.row_index, res_if.last_row);
          fail_count++;
        end else begin
          want = row_sums_due.pop_front();
          if (res_if.row_result !== want.sum) begin
            $display("%0t: row_result expected %0d, actual %0d", $time, want.sum,
                     res_if.row_result);
            fail_count++;
          end
          if (res_if.row_index !== want.row) begin
            $display("%0t: row_index expected %0d, actual %0d", $time, want.row,
                     res_if.row_index);
            fail_count++;
          end
          if (res_if.last_row !== want.last) begin
            $display("%0t: last_row expected %0b, actual %0b", $time, want.last,
                     res_if.last_row);
            fail_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side. All tasks below are entered and left at a falling edge.
  // --------------------------------------------------------------------------

  // Offers one item, waits for it to be accepted, and records the row sum it
  // causes, if any. A typed expectation from the directed table replaces the
  // predicted one, while the predictor still advances.
  task automatic send_item(input logic req_type, input logic [VAL_W-1:0] value,
                           input logic typed, input row_sum_t typed_sum);
    row_sum_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.req_type = req_type;
    req_if.element_value = value;
    do @(posedge clk); while (!req_if.ready);
    if (predict_row_sum(req_type, value, predicted)) begin
      row_sums_due.push_back(typed ? typed_sum : predicted);
    end
    @(negedge clk);
  endtask

  // Stops offering items until every predicted row sum has come out, then
  // lets the pipeline settle, since a partial row may still be in flight.
  task automatic wait_results_drained();
    req_if.valid = 1'b0;
    while (row_sums_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the size register while the block is idle. Counters are kept by
  // the block across the write, and so they are by the predictor.
  task automatic set_matrix_size(input logic [CFG_W-1:0] req_size);
    wait_results_drained();
    cfg_if.valid = 1'b1;
    cfg_if.matrix_size = req_size;
    do @(posedge clk); while (!cfg_if.ready);
    size_reg = req_size;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main stimulus.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned req_size;
    int unsigned n;
    int unsigned rows;
    int          pattern_items;
    int          wait_cycles;
    bit          first;

    // Every input known from time zero, reset held low from the start.
    rst_n = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.matrix_size = '0;
    req_if.valid = 1'b0;
    req_if.req_type = mvm_pkg::REQ_VECTOR;
    req_if.element_value = '0;
    fail_count = 0;
    hold_left = 0;
    send_idle_pct = 6;
    recv_stall_pct = 83;
    load_pos = 0;
    col_cnt = 0;
    row_cnt = 0;
    row_acc = '0;
    size_reg = mvm_pkg::SIZE_RESET;

    // Directed table. Expected sums are typed in only for the one-element
    // cases, where they are a single product of the corner values.
    // Size one: every matrix item is a whole row and the final row.
    dir_steps.push_back('{STEP_SIZE, 16'd1, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_VECTOR, 16'h7FFF, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_MATRIX, 16'h7FFF, 1'b1, '{48'sd1073676289, 10'd0, 1'b1}});
    dir_steps.push_back('{STEP_VECTOR, 16'h8000, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_MATRIX, 16'h8000, 1'b1, '{48'sd1073741824, 10'd0, 1'b1}});
    dir_steps.push_back('{STEP_MATRIX, 16'h7FFF, 1'b1, '{-48'sd1073709056, 10'd0, 1'b1}});
    // A size of zero behaves as one.
    dir_steps.push_back('{STEP_SIZE, 16'd0, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_VECTOR, 16'hFFFF, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_MATRIX, 16'h0001, 1'b1, '{-48'sd1, 10'd0, 1'b1}});
    // Size four: full vector, two overwrites that leave the load position at
    // two, one full row and half of the next.
    dir_steps.push_back('{STEP_SIZE, 16'd4, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_VECTOR, 16'h4000, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_VECTOR, 16'hC000, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_VECTOR, 16'h2000, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_VECTOR, 16'h0001, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_VECTOR, 16'h7FFF, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_VECTOR, 16'h8000, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_MATRIX, 16'h5555, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_MATRIX, 16'hAAAA, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_MATRIX, 16'h7FFF, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_MATRIX, 16'h8000, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_MATRIX, 16'h0100, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_MATRIX, 16'hFF00, 1'b0, NO_SUM});
    // Shrink to one in mid-row: the column and row counters already sit past
    // the new size, so the next matrix item closes the row as the final one,
    // and the next vector load writes at position two before wrapping.
    dir_steps.push_back('{STEP_SIZE, 16'd1, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_MATRIX, 16'h4000, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_VECTOR, 16'h3FFF, 1'b0, NO_SUM});
    dir_steps.push_back('{STEP_MATRIX, 16'h7FFF, 1'b0, NO_SUM});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == STEP_SIZE) begin
        set_matrix_size(dir_steps[i].value[CFG_W-1:0]);
      end else begin
        send_item((dir_steps[i].kind == STEP_MATRIX) ? mvm_pkg::REQ_MATRIX
                                                     : mvm_pkg::REQ_VECTOR,
                  dir_steps[i].value, dir_steps[i].typed, dir_steps[i].want);
      end
    end

    // Random part under three stall patterns: sender rarely idle with the
    // receiver mostly stalled, then the reverse, then no idling at all.
    for (int pattern = 0; pattern < 3; pattern++) begin
      case (pattern)
        0: begin
          send_idle_pct = 6;
          recv_stall_pct = 83;
        end
        1: begin
          send_idle_pct = 83;
          recv_stall_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase

      // Once, an over-range size: it clamps to the maximum, so sixteen vector
      // loads neither wrap nor end anything and eight matrix items stay inside
      // one row. This also writes every vector entry that the small sizes
      // below can ever read, and leaves a row open for the next size write.
      if (pattern == 0) begin
        set_matrix_size({CFG_W{1'b1}});
        repeat (16) send_item(mvm_pkg::REQ_VECTOR, rand_element(), 1'b0, NO_SUM);
        repeat (8) send_item(mvm_pkg::REQ_MATRIX, rand_element(), 1'b0, NO_SUM);
      end

      pattern_items = 0;
      first = 1'b1;
      while (pattern_items < ITEMS_PER_PATTERN) begin
        // Mostly small sizes; zero and one show up now and then.
        if (pattern == 2 && first) begin
          req_size = 2;
        end else begin
          case ($urandom_range(0, 7))
            0:       req_size = 0;
            1:       req_size = 1;
            2:       req_size = 2;
            default: req_size = $urandom_range(3, 12);
          endcase
        end
        set_matrix_size(req_size[CFG_W-1:0]);
        n = (req_size == 0) ? 1 : req_size;

        // With the sender at full rate, the receiver holds off for a long
        // stretch so the item queue fills and the input stalls.
        if (pattern == 2 && first) begin
          hold_left = 400;
          rows = 24;
        end else begin
          rows = $urandom_range(1, 48 / n);
        end

        // A well-formed sequence: the whole vector, then whole rows.
        repeat (n) send_item(mvm_pkg::REQ_VECTOR, rand_element(), 1'b0, NO_SUM);
        pattern_items += n;
        for (int r = 0; r < rows; r++) begin
          // Once, the sender stops in mid-matrix until all results are in.
          if (pattern == 1 && first && r == rows / 2) wait_results_drained();
          for (int c = 0; c < n; c++) begin
            // Occasional stray vector load in the middle of a row.
            if ($urandom_range(0, 19) == 0) begin
              send_item(mvm_pkg::REQ_VECTOR, rand_element(), 1'b0, NO_SUM);
              pattern_items++;
            end
            send_item(mvm_pkg::REQ_MATRIX, rand_element(), 1'b0, NO_SUM);
            pattern_items++;
          end
        end

        // Sometimes a row is left unfinished, so the next size write lands
        // in mid-stream.
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, n)) begin
            send_item(mvm_pkg::REQ_MATRIX, rand_element(), 1'b0, NO_SUM);
            pattern_items++;
          end
        end
        first = 1'b0;
      end
    end

    // Let every outstanding result come out, then watch a while longer for
    // anything extra.
    req_if.valid = 1'b0;
    wait_cycles = 0;
    while (row_sums_due.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    if (row_sums_due.size() != 0) begin
      $display("%0t: %0d expected result items never arrived", $time,
               row_sums_due.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mvm_pkg.sv
hdl/mvm_in_if.sv
hdl/mvm_out_if.sv
hdl/mvm_cfg_if.sv
hdl/mvm_front.sv
hdl/mvm_queue.sv
hdl/mvm_back.sv
hdl/matrix_vector_multiply_core.sv
dv/tb.sv
